@@ hw/rtl/pcxr_pkg.sv @@
package pcxr_pkg;

    localparam logic [1:0] MODE_1BIT = 2'd0;
    localparam logic [1:0] MODE_4BIT = 2'd1;

    localparam logic [1:0] MARKER_TAG = 2'b11;

    typedef enum logic [1:0] {
        REG_PIXEL_MODE = 2'd0,
        REG_ROW_WIDTH  = 2'd1,
        REG_ROW_TOTAL  = 2'd2,
        REG_SKIP_PAD   = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [1:0]  pixel_mode;
        logic [15:0] row_width;
        logic [15:0] row_total;
        logic        skip_pad_byte;
    } t_cfg;

    typedef struct packed {
        logic [7:0] value;
        logic [5:0] count;
    } t_item;

    typedef struct packed {
        logic busy;
        logic done;
        logic row_skip;
    } t_back_status;

    typedef struct packed {
        logic [7:0] data;
        logic       row_end;
        logic       image_end;
    } t_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_FLUSH
    } t_back_state;

endpackage

@@ hw/rtl/pcxr_queue.sv @@
module pcxr_queue
    import pcxr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       w_do_push;
    logic       w_do_pop;

    assign w_do_push = i_push && (r_fill != 2'd2);
    assign w_do_pop  = i_pop && (r_fill != 2'd0);
    assign o_valid   = (r_fill != 2'd0);
    assign o_item    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_do_push && !w_do_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (w_do_pop && !w_do_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

@@ hw/rtl/pcxr_front.sv @@
module pcxr_front
    import pcxr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_byte,
    input  logic         i_skip_pad_byte,
    input  t_back_status i_status,
    output logic         o_push,
    output t_item        o_item
);

    logic       r_await_value;
    logic [5:0] r_pending_count;
    logic       r_skip_next;
    logic       n_await_value;
    logic [5:0] n_pending_count;
    logic       n_skip_next;

    always_comb begin
        n_await_value   = r_await_value;
        n_pending_count = r_pending_count;
        n_skip_next     = r_skip_next;
        o_push          = 1'b0;
        o_item.value    = i_byte;
        o_item.count    = 6'd1;
        if (i_status.row_skip) begin
            n_skip_next = i_skip_pad_byte;
        end
        if (i_accept && !i_status.done) begin
            priority if (r_skip_next) begin
                n_skip_next = 1'b0;
            end else if (r_await_value) begin
                n_await_value = 1'b0;
                o_item.count  = r_pending_count;
                o_push        = 1'b1;
            end else if (i_byte[7:6] == MARKER_TAG) begin
                n_await_value   = 1'b1;
                n_pending_count = i_byte[5:0];
            end else begin
                o_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await_value   <= 1'b0;
            r_pending_count <= 6'd0;
            r_skip_next     <= 1'b0;
        end else begin
            r_await_value   <= n_await_value;
            r_pending_count <= n_pending_count;
            r_skip_next     <= n_skip_next;
        end
    end

endmodule

@@ hw/rtl/pcxr_back.sv @@
module pcxr_back
    import pcxr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_q_valid,
    input  t_item        i_q_item,
    output logic         o_q_pop,
    output t_back_status o_status,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [7:0]   o_m_tdata,
    output logic         o_m_tlast,
    output logic [1:0]   o_m_tuser
);

    t_back_state r_state, n_state;
    logic [7:0]  r_value, n_value;
    logic [5:0]  r_count, n_count;
    logic [2:0]  r_idx, n_idx;
    logic [15:0] r_column, n_column;
    logic [15:0] r_row, n_row;
    logic [2:0]  r_bitpos, n_bitpos;
    logic [7:0]  r_partial, n_partial;
    logic        r_done, n_done;
    t_result     r_held, n_held;
    logic        r_held_v, n_held_v;
    t_result     r_out, n_out;
    logic        r_out_last, n_out_last;
    logic        r_out_v, n_out_v;

    logic        w_zero;
    logic        w_last_pix;
    logic [16:0] w_width;
    logic [16:0] w_total;
    logic [16:0] w_col_inc;
    logic [16:0] w_row_inc;
    logic        w_full;
    logic        w_rend;
    logic        w_iend;
    logic        w_emit;
    logic [7:0]  w_partial_next;
    logic        w_out_free;
    logic        w_row_skip;

    always_comb begin
        unique case (i_cfg.pixel_mode)
            MODE_1BIT: begin
                w_zero     = !r_value[3'd7 - r_idx];
                w_last_pix = (r_idx == 3'd7);
            end
            MODE_4BIT: begin
                w_zero     = r_idx[0] ? (r_value[3:0] == 4'd0) : (r_value[7:4] == 4'd0);
                w_last_pix = r_idx[0];
            end
            default: begin
                w_zero     = (r_value == 8'd0);
                w_last_pix = 1'b1;
            end
        endcase
    end

    assign w_width        = (i_cfg.row_width == 16'd0) ? 17'h10000 : {1'b0, i_cfg.row_width};
    assign w_total        = (i_cfg.row_total == 16'd0) ? 17'h10000 : {1'b0, i_cfg.row_total};
    assign w_col_inc      = {1'b0, r_column} + 17'd1;
    assign w_row_inc      = {1'b0, r_row} + 17'd1;
    assign w_full         = (r_bitpos == 3'd0);
    assign w_rend         = (w_col_inc >= w_width);
    assign w_iend         = w_rend && (w_row_inc >= w_total);
    assign w_emit         = w_full || w_rend;
    assign w_partial_next = r_partial | ({7'd0, w_zero} << r_bitpos);
    assign w_out_free     = !r_out_v || i_m_tready;

    always_comb begin
        n_state    = r_state;
        n_value    = r_value;
        n_count    = r_count;
        n_idx      = r_idx;
        n_column   = r_column;
        n_row      = r_row;
        n_bitpos   = r_bitpos;
        n_partial  = r_partial;
        n_done     = r_done;
        n_held     = r_held;
        n_held_v   = r_held_v;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_v    = r_out_v && !i_m_tready;
        o_q_pop    = 1'b0;
        w_row_skip = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    n_value = i_q_item.value;
                    n_count = i_q_item.count;
                    n_idx   = 3'd0;
                    if (i_q_item.count != 6'd0) begin
                        n_state = BK_RUN;
                    end
                end
            end
            BK_RUN: begin
                if (!(w_emit && r_held_v && !w_out_free)) begin
                    if (w_emit) begin
                        if (r_held_v) begin
                            n_out      = r_held;
                            n_out_last = 1'b0;
                            n_out_v    = 1'b1;
                        end
                        n_held.data      = w_partial_next;
                        n_held.row_end   = w_rend;
                        n_held.image_end = w_iend;
                        n_held_v         = 1'b1;
                        n_partial        = 8'd0;
                        n_bitpos         = 3'd7;
                    end else begin
                        n_partial = w_partial_next;
                        n_bitpos  = r_bitpos - 3'd1;
                    end
                    n_column = w_rend ? 16'd0 : w_col_inc[15:0];
                    if (w_rend) begin
                        if (w_iend) begin
                            n_done = 1'b1;
                        end else begin
                            n_row      = w_row_inc[15:0];
                            w_row_skip = 1'b1;
                        end
                        n_state = BK_FLUSH;
                    end else if (w_last_pix) begin
                        n_idx   = 3'd0;
                        n_count = r_count - 6'd1;
                        if (r_count == 6'd1) begin
                            n_state = BK_FLUSH;
                        end
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            BK_FLUSH: begin
                if (!r_held_v) begin
                    n_state = BK_IDLE;
                end else if (w_out_free) begin
                    n_out      = r_held;
                    n_out_last = 1'b1;
                    n_out_v    = 1'b1;
                    n_held_v   = 1'b0;
                    n_state    = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_column  <= 16'd0;
            r_row     <= 16'd0;
            r_bitpos  <= 3'd7;
            r_partial <= 8'd0;
            r_done    <= 1'b0;
            r_held_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_column  <= n_column;
            r_row     <= n_row;
            r_bitpos  <= n_bitpos;
            r_partial <= n_partial;
            r_done    <= n_done;
            r_held_v  <= n_held_v;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_count    <= n_count;
        r_idx      <= n_idx;
        r_held     <= n_held;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_status.busy     = (r_state != BK_IDLE);
    assign o_status.done     = r_done;
    assign o_status.row_skip = w_row_skip;

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out.data;
    assign o_m_tlast  = r_out.row_end;
    assign o_m_tuser  = {r_out_last, r_out.image_end};

endmodule

@@ hw/rtl/pcx_rle_to_mono_raster_top.sv @@
// Channel     Direction  Signals                          Contents
// s_axis      in         tvalid tready tdata[7:0]         encoded PCX data byte
// m_axis      out        tvalid tready tdata[7:0] tlast   packed raster byte, tlast = row end
//                        tuser[1:0]                       bit 0 image end, bit 1 last of input
// cfg         in         i_cfg_valid o_cfg_ready          register index and write data
//
// The pixel engine handles one pixel per cycle unless a stalled output holds it; a literal
// byte holds one, two or eight pixels by pixel mode, a run its count times that, and a run
// marker or a pad byte yields no pixel.
// A new byte is taken only once the engine has finished the previous one.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds the engine only when a second result is ready to leave.
module pcx_rle_to_mono_raster_top
    import pcxr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // [0] image_end, [1] last_of_input
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg         r_cfg;
    t_back_status w_status;
    logic         w_accept;
    logic         w_push;
    t_item        w_push_item;
    logic         w_q_valid;
    t_item        w_q_item;
    logic         w_q_pop;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !w_q_valid && !w_status.busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_mode    <= MODE_1BIT;
            r_cfg.row_width     <= 16'd1;
            r_cfg.row_total     <= 16'd1;
            r_cfg.skip_pad_byte <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_PIXEL_MODE: r_cfg.pixel_mode    <= i_cfg_data[1:0];
                REG_ROW_WIDTH:  r_cfg.row_width     <= i_cfg_data;
                REG_ROW_TOTAL:  r_cfg.row_total     <= i_cfg_data;
                REG_SKIP_PAD:   r_cfg.skip_pad_byte <= i_cfg_data[0];
                default:        r_cfg.skip_pad_byte <= r_cfg.skip_pad_byte;
            endcase
        end
    end

    pcxr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_byte          (s_axis_tdata),
        .i_skip_pad_byte (r_cfg.skip_pad_byte),
        .i_status        (w_status),
        .o_push          (w_push),
        .o_item          (w_push_item)
    );

    pcxr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    pcxr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .o_status   (w_status),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import pcxr_pkg::*;

    localparam int ENGINE_TAIL    = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 48;
    localparam int REPORT_LIMIT   = 10;
    localparam int SRC_IDLE [3]   = '{21, 83, 0};
    localparam int SNK_IDLE [3]   = '{83, 21, 0};

    localparam logic [1:0] MODE_8BIT     = 2'd2;
    localparam logic [1:0] MODE_8BIT_ALT = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       row_end;
        logic       image_end;
        logic       last;
    } t_raster_beat;

    typedef enum logic {VEC_BYTE, VEC_REG} t_vec_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} t_vec_check;

    typedef struct packed {
        t_vec_kind    kind;
        t_reg_index   index;
        logic [15:0]  value;
        t_vec_check   check;
        t_raster_beat beat;
    } t_vector;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_reg_index  i_cfg_index = REG_PIXEL_MODE;
    logic [15:0] i_cfg_data = '0;

    int src_idle_pct = SRC_IDLE[0];
    int snk_idle_pct = SNK_IDLE[0];
    int error_count = 0;
    int beats_checked = 0;
    int bytes_in = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;

    // Decoder state mirrored by the testbench.
    logic [1:0]   mdl_mode = MODE_1BIT;
    logic [15:0]  mdl_width = 16'd1;
    logic [15:0]  mdl_rows = 16'd1;
    logic         mdl_skip = 1'b0;
    logic         run_armed = 1'b0;
    logic [5:0]   run_length = '0;
    logic         pad_due = 1'b0;
    int unsigned  col_pos = 0;
    int unsigned  row_pos = 0;
    logic [2:0]   fill_bit = 3'd7;
    logic [7:0]   fill_byte = '0;
    logic         image_done = 1'b0;
    t_raster_beat step_beats[$];
    t_raster_beat raster_expect[$];

    pcx_rle_to_mono_raster_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    function automatic void decode_pcx_byte(logic [7:0] b);
        int unsigned reps;
        int unsigned per_byte;
        int unsigned idx;
        int unsigned width;
        int unsigned rows;
        logic        zero_pix;
        logic        full;
        logic        row_done;
        step_beats.delete();
        if (image_done) return;
        if (pad_due) begin
            pad_due = 1'b0;
            return;
        end
        if (run_armed) begin
            run_armed = 1'b0;
            reps = run_length;
        end else if (b[7:6] == MARKER_TAG) begin
            run_armed = 1'b1;
            run_length = b[5:0];
            return;
        end else begin
            reps = 1;
        end
        per_byte = (mdl_mode == MODE_1BIT) ? 8 : ((mdl_mode == MODE_4BIT) ? 2 : 1);
        width = (mdl_width == 16'd0) ? 65536 : mdl_width;
        rows = (mdl_rows == 16'd0) ? 65536 : mdl_rows;
        idx = 0;
        while (reps > 0) begin
            case (mdl_mode)
                MODE_1BIT: zero_pix = !b[7 - idx];
                MODE_4BIT: zero_pix = idx[0] ? (b[3:0] == 4'd0) : (b[7:4] == 4'd0);
                default:   zero_pix = (b == 8'd0);
            endcase
            if (zero_pix) fill_byte[fill_bit] = 1'b1;
            full = (fill_bit == 3'd0);
            fill_bit = fill_bit - 3'd1;
            row_done = (col_pos + 1 >= width);
            col_pos = row_done ? 0 : col_pos + 1;
            if (full || row_done) begin
                step_beats.push_back('{fill_byte, row_done,
                                       row_done && (row_pos + 1 >= rows), 1'b0});
                fill_byte = '0;
                fill_bit = 3'd7;
            end
            if (row_done) begin
                if (row_pos + 1 >= rows) image_done = 1'b1;
                else row_pos = row_pos + 1;
                pad_due = image_done ? 1'b0 : mdl_skip;
                break;
            end
            idx++;
            if (idx >= per_byte) begin
                idx = 0;
                reps--;
            end
        end
        if (step_beats.size() != 0) step_beats[step_beats.size() - 1].last = 1'b1;
    endfunction

    function automatic void report_mismatch(string what, t_raster_beat want, t_raster_beat got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("Mismatch at %0t: %s; expected data %02h row_end %0b image_end %0b ",
                     $time, what, want.data, want.row_end, want.image_end,
                     "last %0b, got data %02h row_end %0b image_end %0b last %0b",
                     want.last, got.data, got.row_end, got.image_end, got.last);
    endfunction

    function automatic t_vector reg_vec(t_reg_index index, logic [15:0] value);
        return '{VEC_REG, index, value, CHK_NONE, '0};
    endfunction

    function automatic t_vector byte_vec(logic [7:0] b, t_vec_check check, logic [7:0] data,
                                         logic rend);
        return '{VEC_BYTE, REG_PIXEL_MODE, {8'h00, b}, check, '{data, rend, 1'b0, 1'b1}};
    endfunction

    task automatic send_byte(logic [7:0] b, bit keep_model);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_in++;
        decode_pcx_byte(b);
        if (keep_model) begin
            foreach (step_beats[k]) raster_expect.push_back(step_beats[k]);
        end
    endtask

    task automatic write_reg(t_reg_index index, logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        while (raster_expect.size() != 0) @(posedge i_clk);
        repeat (ENGINE_TAIL) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            REG_PIXEL_MODE: mdl_mode  = value[1:0];
            REG_ROW_WIDTH:  mdl_width = value;
            REG_ROW_TOTAL:  mdl_rows  = value;
            REG_SKIP_PAD:   mdl_skip  = value[0];
            default:        ;
        endcase
        reg_writes++;
    endtask

    always @(posedge i_clk) begin
        t_raster_beat got;
        t_raster_beat want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]};
                beats_checked++;
                if (raster_expect.size() == 0) begin
                    report_mismatch("transfer with nothing expected", '0, got);
                end else begin
                    want = raster_expect.pop_front();
                    if (got.data !== want.data || got.row_end !== want.row_end ||
                        got.image_end !== want.image_end || got.last !== want.last)
                        report_mismatch("field mismatch", want, got);
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: nothing transferred for %0d cycles.", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        t_vector     directed_vec[$];
        t_vector     v;
        logic [7:0]  b;
        logic [15:0] width;
        int unsigned pick;
        int          target;

        directed_vec = '{
            reg_vec(REG_ROW_TOTAL, 16'd0),
            reg_vec(REG_ROW_WIDTH, 16'd8),
            byte_vec(8'h00, CHK_ONE, 8'hFF, 1'b1),
            byte_vec(8'h3F, CHK_ONE, 8'hC0, 1'b1),
            byte_vec(8'hBF, CHK_ONE, 8'h40, 1'b1),
            byte_vec(8'h7F, CHK_ONE, 8'h80, 1'b1),
            byte_vec(8'hC0, CHK_NONE, 8'h00, 1'b0),
            byte_vec(8'h12, CHK_NONE, 8'h00, 1'b0),
            byte_vec(8'hC2, CHK_NONE, 8'h00, 1'b0),
            byte_vec(8'hFF, CHK_ONE, 8'h00, 1'b1),
            byte_vec(8'hFF, CHK_NONE, 8'h00, 1'b0),
            byte_vec(8'h00, CHK_ONE, 8'hFF, 1'b1),
            reg_vec(REG_SKIP_PAD, 16'd1),
            byte_vec(8'h55, CHK_ONE, 8'hAA, 1'b1),
            byte_vec(8'hC5, CHK_NONE, 8'h00, 1'b0),
            byte_vec(8'h0F, CHK_ONE, 8'hF0, 1'b1),
            byte_vec(8'hFF, CHK_NONE, 8'h00, 1'b0),
            reg_vec(REG_SKIP_PAD, 16'd0),
            reg_vec(REG_PIXEL_MODE, 16'(MODE_4BIT)),
            byte_vec(8'h0F, CHK_MODEL, 8'h00, 1'b0),
            byte_vec(8'hF0, CHK_MODEL, 8'h00, 1'b0),
            byte_vec(8'hC3, CHK_MODEL, 8'h00, 1'b0),
            byte_vec(8'h10, CHK_MODEL, 8'h00, 1'b0),
            reg_vec(REG_PIXEL_MODE, 16'(MODE_8BIT)),
            reg_vec(REG_ROW_WIDTH, 16'd0),
            byte_vec(8'h01, CHK_MODEL, 8'h00, 1'b0),
            byte_vec(8'hC9, CHK_MODEL, 8'h00, 1'b0),
            byte_vec(8'h00, CHK_MODEL, 8'h00, 1'b0),
            reg_vec(REG_ROW_WIDTH, 16'd3),
            byte_vec(8'h00, CHK_MODEL, 8'h00, 1'b0),
            reg_vec(REG_PIXEL_MODE, 16'(MODE_8BIT_ALT)),
            byte_vec(8'h00, CHK_MODEL, 8'h00, 1'b0),
            byte_vec(8'h80, CHK_MODEL, 8'h00, 1'b0),
            reg_vec(REG_ROW_WIDTH, 16'hFFFF),
            reg_vec(REG_ROW_TOTAL, 16'hFFFF),
            reg_vec(REG_PIXEL_MODE, 16'(MODE_1BIT)),
            byte_vec(8'hFF, CHK_MODEL, 8'h00, 1'b0),
            byte_vec(8'hA5, CHK_MODEL, 8'h00, 1'b0)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_vec[k]) begin
            v = directed_vec[k];
            if (v.kind == VEC_REG) begin
                write_reg(v.index, v.value);
            end else begin
                send_byte(v.value[7:0], v.check == CHK_MODEL);
                if (v.check == CHK_ONE) raster_expect.push_back(v.beat);
            end
        end

        // The row total stays far above the rows reached so the image ends only at the close.
        target = bytes_in;
        for (int p = 0; p < 3; p++) begin
            src_idle_pct = SRC_IDLE[p];
            snk_idle_pct = SNK_IDLE[p];
            pick = $urandom_range(9);
            if (pick < 6) width = 16'($urandom_range(24, 1));
            else if (pick == 6) width = 16'd0;
            else if (pick == 7) width = 16'hFFFF;
            else width = 16'($urandom_range(3000, 25));
            write_reg(REG_PIXEL_MODE, 16'($urandom_range(3)));
            write_reg(REG_ROW_WIDTH, width);
            write_reg(REG_ROW_TOTAL,
                      ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(65535, 1024)));
            write_reg(REG_SKIP_PAD, 16'($urandom_range(1)));
            target += PHASE_ITEMS;
            while (bytes_in < target) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    b = 8'($urandom_range(255));
                    if (b[7:6] == MARKER_TAG) b[6] = 1'b0;
                    send_byte(b, 1'b1);
                end else if (pick < 88) begin
                    b = {MARKER_TAG, ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                               : 6'($urandom_range(6))};
                    send_byte(b, 1'b1);
                    send_byte(8'($urandom_range(255)), 1'b1);
                end else begin
                    send_byte(8'($urandom_range(255)), 1'b1);
                end
            end
        end

        // Close the image, then confirm that later bytes are swallowed without output.
        write_reg(REG_ROW_TOTAL, 16'd1);
        write_reg(REG_PIXEL_MODE, 16'(MODE_8BIT));
        write_reg(REG_ROW_WIDTH, 16'd4);
        for (int k = 0; k < 8; k++) send_byte(8'h00, 1'b1);
        for (int k = 0; k < 4; k++) send_byte(8'($urandom_range(255)), 1'b1);
        s_axis_tvalid <= 1'b0;
        while (raster_expect.size() != 0) @(posedge i_clk);
        repeat (ENGINE_TAIL) @(posedge i_clk);

        $display("Run covered %0d input bytes, %0d register writes and %0d raster transfers.",
                 bytes_in, reg_writes, beats_checked);
        $display("All four pixel modes, extreme row sizes, pad skipping and the image end "
                 , "were exercised under varied stalls; %0d mismatches.", error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
